FILE: hdl/iqs_pkg.sv
`default_nettype none
package iqs_pkg;

	localparam logic [31:0] HASH_BASIS     = 32'd2166136261;
	localparam logic [7:0]  SENTINEL_RESET = 8'hA5;

	localparam int SUM_W    = 20;
	localparam int POWER_W  = 24;
	localparam int COUNT_W  = 17;
	localparam int CHANGE_W = 16;

	localparam logic signed [SUM_W:0] SUM_MAX = 21'sd524287;
	localparam logic signed [SUM_W:0] SUM_MIN = -21'sd524288;

	// Configuration register indexes (word address bits above the byte lane)
	localparam logic REG_SENTINEL = 1'b0;

	typedef struct packed {
		logic       valid;
		logic [7:0] sample;
		logic       last;
	} iqs_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]      sentinel_count;
		logic [CHANGE_W-1:0]     changed_count;
		logic [COUNT_W-1:0]      nonzero_count;
		logic [POWER_W-1:0]      power_total;
		logic signed [SUM_W-1:0] q_total;
		logic signed [SUM_W-1:0] i_total;
		logic [31:0]             hash_value;
	} iqs_result_t;

	// FNV prime 16777619 = 2^24 + 256 + 128 + 16 + 2 + 1: shift-add, wraps mod 2^32.
	function automatic logic [31:0] fnv_mul(input logic [31:0] x);
		fnv_mul = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sum(
		input logic signed [SUM_W-1:0] acc,
		input logic signed [3:0]       add
	);
		logic signed [SUM_W:0] s;
		s = {acc[SUM_W-1], acc} + {{(SUM_W-3){add[3]}}, add};
		if (s > SUM_MAX)
			sat_sum = SUM_MAX[SUM_W-1:0];
		else if (s < SUM_MIN)
			sat_sum = SUM_MIN[SUM_W-1:0];
		else
			sat_sum = s[SUM_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: hdl/iq_capture_statistics.sv
// iq_capture_statistics: per-run statistics over packed IQ capture bytes.
// Slave stream (s_*): one byte per word, I in bits 7:4, Q in bits 3:0;
// s_tlast marks the final byte of a capture run.
// Master stream (m_*): one summary word per run (FNV-1a hash, saturated
// I/Q sums, power sum, nonzero/changed/sentinel counts), sent after the
// byte marked last has been folded in.
// APB port: register 0 at byte address 0 holds the sentinel byte (reset 0xA5).
// Throughput: one byte per cycle, except that a last byte waits while
// an untaken summary holds the output register; a byte passes through
// the input register, then the accumulators and the output register
// load at the same edge; m_tvalid is set as the last byte moves on from
// the input register. The hash update is a shift-add of the FNV prime.
// Stall: the output register holds a summary until m_tready; bytes that
// are not last keep flowing meanwhile. Only a second last byte waits.
// Reset: run state returns to the FNV basis and zero counts; the
// sentinel register returns to 0xA5. After each summary the run state
// clears by itself while the sentinel keeps its value.
`default_nettype none
module iq_capture_statistics
	import iqs_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// slave stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] sample_byte
	input  wire logic         s_tlast,
	// master stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [31:0] hash_value, [51:32] i_total, [71:52] q_total,
	// [95:72] power_total, [112:96] nonzero_count, [128:113] changed_count,
	// [145:129] sentinel_count, [151:146] zero
	output logic      [151:0] m_tdata,
	// APB configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready
);

	logic        valid_s1, last_s1;
	logic [7:0]  sample_s1;
	logic        out_valid_q;
	iqs_result_t out_q;
	iqs_result_t result;
	iqs_item_t   item;
	logic [7:0]  sentinel;
	logic        adv_s1;

	iqs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.sentinel (sentinel)
	);

	// A last byte may only advance when the output register is free or draining.
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	assign item.valid  = adv_s1;
	assign item.sample = sample_s1;
	assign item.last   = last_s1;

	iqs_stats u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.sentinel (sentinel),
		.result   (result)
	);

	// Input register: hold the word until the accumulators take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= s_tdata;
			last_s1   <= s_tlast;
		end
	end

	// Output register: load a summary on the last byte, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1 && last_s1)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1)
			out_q <= result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q};

endmodule
`default_nettype wire

FILE: hdl/iqs_cfg.sv
`default_nettype none
module iqs_cfg
	import iqs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [7:0]  sentinel
);

	logic [7:0] sentinel_q;
	logic       wr_en;

	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite && (paddr[2] == REG_SENTINEL);
	assign sentinel = sentinel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sentinel_q <= SENTINEL_RESET;
		else if (wr_en)
			sentinel_q <= pwdata[7:0];
	end

	always_comb begin
		unique case (paddr[2])
			REG_SENTINEL: prdata = {24'd0, sentinel_q};
			default:      prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/iqs_stats.sv
`default_nettype none
module iqs_stats
	import iqs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire iqs_item_t   item,
	input  wire logic [7:0]  sentinel,
	output iqs_result_t      result
);

	logic [31:0]             hash_q;
	logic signed [SUM_W-1:0] i_q, q_q;
	logic [POWER_W-1:0]      power_q;
	logic [COUNT_W-1:0]      nonzero_q, sent_q;
	logic [CHANGE_W-1:0]     changed_q;
	logic [7:0]              prev_q;
	logic                    first_q;

	logic signed [3:0]   iv, qv;
	logic [7:0]          isq, qsq;
	logic [POWER_W:0]    pw_sum;
	logic                changed;

	assign iv = item.sample[7:4];
	assign qv = item.sample[3:0];
	// Squares of a 4-bit signed value fit in 8 bits (max 64 each).
	assign isq = 8'(iv * iv);
	assign qsq = 8'(qv * qv);
	assign pw_sum = {1'b0, power_q} + {{(POWER_W-8){1'b0}}, isq}
		+ {{(POWER_W-8){1'b0}}, qsq};
	assign changed = !first_q && (item.sample != prev_q);

	always_comb begin
		result.hash_value = fnv_mul(hash_q ^ {24'd0, item.sample});
		result.i_total    = sat_sum(i_q, iv);
		result.q_total    = sat_sum(q_q, qv);
		result.power_total = pw_sum[POWER_W] ? {POWER_W{1'b1}} : pw_sum[POWER_W-1:0];
		result.nonzero_count = nonzero_q;
		if (item.sample != 8'd0 && !(&nonzero_q))
			result.nonzero_count = nonzero_q + 1'b1;
		result.sentinel_count = sent_q;
		if (item.sample == sentinel && !(&sent_q))
			result.sentinel_count = sent_q + 1'b1;
		result.changed_count = changed_q;
		if (changed && !(&changed_q))
			result.changed_count = changed_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q    <= HASH_BASIS;
			i_q       <= '0;
			q_q       <= '0;
			power_q   <= '0;
			nonzero_q <= '0;
			sent_q    <= '0;
			changed_q <= '0;
			prev_q    <= '0;
			first_q   <= 1'b1;
		end else if (item.valid) begin
			if (item.last) begin
				hash_q    <= HASH_BASIS;
				i_q       <= '0;
				q_q       <= '0;
				power_q   <= '0;
				nonzero_q <= '0;
				sent_q    <= '0;
				changed_q <= '0;
				prev_q    <= '0;
				first_q   <= 1'b1;
			end else begin
				hash_q    <= result.hash_value;
				i_q       <= result.i_total;
				q_q       <= result.q_total;
				power_q   <= result.power_total;
				nonzero_q <= result.nonzero_count;
				sent_q    <= result.sentinel_count;
				changed_q <= result.changed_count;
				prev_q    <= item.sample;
				first_q   <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: tb/iq_capture_statistics_tb.sv
`default_nettype none
module iq_capture_statistics_tb
	import iqs_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// FNV-1a prime and the saturation limits of the summary fields
	localparam logic [31:0] FNV_PRIME  = 32'd16777619;
	localparam int          SUM_HI     = 524287;
	localparam int          SUM_LO     = -524288;
	localparam int          POWER_HI   = 16777215;
	localparam int          COUNT_HI   = 131071;
	localparam int          CHANGE_HI  = 65535;

	// Register 0 sits at byte address 0; the other word slot maps to nothing
	localparam logic [2:0] ADDR_SENTINEL = {REG_SENTINEL, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED = {~REG_SENTINEL, 2'b00};

	// Watchdog limit and settling waits
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;

	// Expected run summaries, computed byte by byte as words are accepted
	class capture_summary_board;
		logic [7:0]  sentinel;
		logic [31:0] hash;
		int          i_sum;
		int          q_sum;
		int          pwr_acc;
		int          nonzero_cnt;
		int          changed_cnt;
		int          sentinel_cnt;
		logic [7:0]  prev_byte;
		bit          first_byte;
		iqs_result_t expected_summaries[$];
		int          errors;

		function new();
			sentinel = SENTINEL_RESET;
			errors = 0;
			clear_run();
		endfunction

		function void clear_run();
			hash = HASH_BASIS;
			i_sum = 0;
			q_sum = 0;
			pwr_acc = 0;
			nonzero_cnt = 0;
			changed_cnt = 0;
			sentinel_cnt = 0;
			prev_byte = 8'h00;
			first_byte = 1'b1;
		endfunction

		function int clamp(int v, int lo, int hi);
			return (v > hi) ? hi : ((v < lo) ? lo : v);
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			logic signed [3:0] i_nib;
			logic signed [3:0] q_nib;
			int                iv;
			int                qv;
			iqs_result_t       summary;
			i_nib = b[7:4];
			q_nib = b[3:0];
			iv = i_nib;
			qv = q_nib;
			hash = (hash ^ {24'd0, b}) * FNV_PRIME;
			i_sum = clamp(i_sum + iv, SUM_LO, SUM_HI);
			q_sum = clamp(q_sum + qv, SUM_LO, SUM_HI);
			pwr_acc = clamp(pwr_acc + iv * iv + qv * qv, 0, POWER_HI);
			if (b != 8'h00)
				nonzero_cnt = clamp(nonzero_cnt + 1, 0, COUNT_HI);
			if (b == sentinel)
				sentinel_cnt = clamp(sentinel_cnt + 1, 0, COUNT_HI);
			// the opening byte of a run never counts as a change
			if (!first_byte && b != prev_byte)
				changed_cnt = clamp(changed_cnt + 1, 0, CHANGE_HI);
			prev_byte = b;
			first_byte = 1'b0;
			if (last) begin
				summary.hash_value     = hash;
				summary.i_total        = i_sum[SUM_W-1:0];
				summary.q_total        = q_sum[SUM_W-1:0];
				summary.power_total    = pwr_acc[POWER_W-1:0];
				summary.nonzero_count  = nonzero_cnt[COUNT_W-1:0];
				summary.changed_count  = changed_cnt[CHANGE_W-1:0];
				summary.sentinel_count = sentinel_cnt[COUNT_W-1:0];
				expected_summaries.push_back(summary);
				clear_run();
			end
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("%0t ns: summary mismatch on %s: got %0h, want %0h",
				$time, what, got, want);
		endtask

		// Unpack in the port order: hash, I, Q, power, nonzero, changed, sentinel
		task check_summary(logic [151:0] word);
			iqs_result_t want;
			if (expected_summaries.size() == 0) begin
				report_mismatch("unexpected summary, hash", word[31:0], 32'd0);
			end else begin
				want = expected_summaries.pop_front();
				if (word[31:0] !== want.hash_value)
					report_mismatch("hash_value", word[31:0], want.hash_value);
				if (word[51:32] !== want.i_total)
					report_mismatch("i_total", {12'd0, word[51:32]}, {12'd0, want.i_total});
				if (word[71:52] !== want.q_total)
					report_mismatch("q_total", {12'd0, word[71:52]}, {12'd0, want.q_total});
				if (word[95:72] !== want.power_total)
					report_mismatch("power_total", {8'd0, word[95:72]},
						{8'd0, want.power_total});
				if (word[112:96] !== want.nonzero_count)
					report_mismatch("nonzero_count", {15'd0, word[112:96]},
						{15'd0, want.nonzero_count});
				if (word[128:113] !== want.changed_count)
					report_mismatch("changed_count", {16'd0, word[128:113]},
						{16'd0, want.changed_count});
				if (word[145:129] !== want.sentinel_count)
					report_mismatch("sentinel_count", {15'd0, word[145:129]},
						{15'd0, want.sentinel_count});
				if (word[151:146] !== 6'd0)
					report_mismatch("pad bits", {26'd0, word[151:146]}, 32'd0);
			end
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;   // [7:0] sample_byte
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// [31:0] hash_value, [51:32] i_total, [71:52] q_total, [95:72] power_total,
	// [112:96] nonzero_count, [128:113] changed_count, [145:129] sentinel_count
	logic [151:0] m_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = 3'd0;
	logic [31:0]  pwdata = 32'd0;
	logic [31:0]  prdata;
	logic         pready;

	capture_summary_board board;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	iq_capture_statistics dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: check every accepted summary word against the oldest
	// expectation, then draw the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_summary(m_tdata);
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: end the run when no word moves on either stream for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("iq_capture_statistics_tb: FAIL");
			$finish;
		end
	end

	// Offer one byte word, idling first at the current sender rate, and
	// record it in the predictor once the handshake completes.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		board.note_byte(b, last);
	endtask

	// Hold the sender until every expected summary has come back.
	task automatic drain_summaries();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.expected_summaries.size() != 0);
	endtask

	// Drain, then let any byte still in the pipeline settle before config.
	task automatic quiesce();
		drain_summaries();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// only the sentinel slot is mapped; the other slot drops the write
		if (addr[2] == REG_SENTINEL)
			board.sentinel = data[7:0];
		@(posedge clk);
	endtask

	// Bias toward the interesting bytes: sentinel hits, repeats, zero, extremes.
	function automatic logic [7:0] pick_byte(input logic [7:0] prev);
		logic [7:0] extremes [7];
		extremes = '{8'h77, 8'h88, 8'h80, 8'h08, 8'h7F, 8'hF7, 8'hFF};
		case ($urandom_range(9))
			0: return board.sentinel;
			1: return prev;
			2: return 8'h00;
			3: return extremes[$urandom_range(6)];
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_run(input int len);
		logic [7:0] b;
		b = 8'($urandom_range(255));
		for (int k = 0; k < len; k++) begin
			b = pick_byte(b);
			send_byte(b, k == len - 1);
		end
	endtask

	// One phase: settle, set the sentinel (with a throwaway write to the
	// unmapped slot), then stream random runs at the given idle and stall rates.
	task automatic run_phase(input int idle, input int stall, input logic [7:0] sentinel,
		input int items);
		logic [31:0] data;
		int          sent;
		int          len;
		quiesce();
		data = $urandom();
		data[7:0] = sentinel;
		write_reg(ADDR_SENTINEL, data);
		write_reg(ADDR_UNMAPPED, $urandom());
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(15) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
			send_run(len);
			sent += len;
			// now and then pause the sender until the output side is empty
			if ($urandom_range(24) == 0)
				drain_summaries();
		end
	endtask

	initial begin
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed runs at the reset sentinel: single-byte runs, nibble
		// extremes, repeats that must not count as changes, sentinel hits.
		send_byte(8'h00, 1'b1);
		send_byte(SENTINEL_RESET, 1'b1);
		send_byte(8'h05, 1'b0);
		send_byte(8'h05, 1'b1);
		send_byte(8'h77, 1'b0);
		send_byte(8'h77, 1'b0);
		send_byte(8'h88, 1'b0);
		send_byte(8'h88, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h08, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hF7, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(SENTINEL_RESET, 1'b0);
		send_byte(SENTINEL_RESET, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);

		run_phase(0, 0, 8'h00, 360);
		run_phase(84, 0, 8'hFF, 360);
		run_phase(0, 84, 8'($urandom_range(255)), 360);
		run_phase(11, 11, 8'($urandom_range(255)), 360);

		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.expected_summaries.size() == 0)
			$display("iq_capture_statistics_tb: PASS");
		else
			$display("iq_capture_statistics_tb: FAIL");
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
hdl/iqs_pkg.sv
hdl/iqs_cfg.sv
hdl/iqs_stats.sv
hdl/iq_capture_statistics.sv
tb/iq_capture_statistics_tb.sv
